// ----- design/iprx_pkg.sv -----
// iprx_pkg: shared types and constants for the IPv4 receive header checker.
// Holds the transaction structs, the verdict codes and the queue depth default.
// No dependencies.
`timescale 1ns / 1ps

package iprx_pkg;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Verdict codes
    localparam logic [2:0] ST_UDP         = 3'd0;
    localparam logic [2:0] ST_ICMP        = 3'd1;
    localparam logic [2:0] ST_OTHER       = 3'd2;
    localparam logic [2:0] ST_WRONG_ADDR  = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;
    localparam logic [2:0] ST_TOO_LONG    = 3'd5;
    localparam logic [2:0] ST_FRAGMENT    = 3'd6;
    localparam logic [2:0] ST_BAD_SUM     = 3'd7;

    // Configuration register indexes
    localparam logic CFG_HOST_ADDRESS  = 1'b0;
    localparam logic CFG_FILTER_ENABLE = 1'b1;

    // One input transaction: a header word
    typedef struct packed {
        logic [15:0] header_word;
        logic        first_word;
        logic [15:0] frame_length;
    } t_in_item;

    // One result transaction: the verdict
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  protocol;
        logic [15:0] payload_length;
    } t_out_item;

    // Finished header handed from front to back
    typedef struct packed {
        logic [31:0] destination;
        logic        version_ok;
        logic [15:0] hdr_total_len;
        logic [15:0] available_length;
        logic        fragment;
        logic        sum_ok;
        logic [7:0]  protocol;
        logic [5:0]  header_bytes;
    } t_job;

endpackage

// ----- design/iprx_front.sv -----
// iprx_front: accepts header words, keeps the ones' complement sum and captures
// the header fields; pushes one job per finished header. Depends on iprx_pkg.
`timescale 1ns / 1ps

module iprx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  iprx_pkg::t_in_item i_item,
    input  logic              i_queue_full,
    output logic              o_push,
    output iprx_pkg::t_job    o_job
);

    // Word positions within the header
    localparam logic [4:0] IDX_TOTAL_LENGTH = 5'd1;
    localparam logic [4:0] IDX_FRAGMENT     = 5'd3;
    localparam logic [4:0] IDX_PROTOCOL     = 5'd4;
    localparam logic [4:0] IDX_DEST_HIGH    = 5'd8;
    localparam logic [4:0] IDX_DEST_LOW     = 5'd9;
    localparam logic [4:0] DEFAULT_WORDS    = 5'd10;
    localparam logic [7:0] VERSION_LOW      = 8'h45;
    localparam logic [7:0] VERSION_HIGH     = 8'h4f;

    logic [4:0]  r_word_index, n_word_index;
    logic [15:0] r_sum, n_sum;
    logic [4:0]  r_hdr_words, n_hdr_words;
    logic [7:0]  r_version, n_version;
    logic [15:0] r_total, n_total;
    logic        r_frag, n_frag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_dest, n_dest;
    logic [15:0] r_avail, n_avail;

    logic        accept;
    logic [4:0]  index_inc;
    logic [16:0] sum_wide;

    function automatic logic version_in_range(input logic [7:0] v);
        return (v >= VERSION_LOW) && (v <= VERSION_HIGH);
    endfunction

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // End-around-carry add of the incoming word
    assign sum_wide  = {1'b0, r_sum} + {1'b0, i_item.header_word};
    assign index_inc = r_word_index + 5'd1;

    // Field capture and header progress
    always_comb begin
        n_word_index = r_word_index;
        n_sum        = r_sum;
        n_hdr_words  = r_hdr_words;
        n_version    = r_version;
        n_total      = r_total;
        n_frag       = r_frag;
        n_proto      = r_proto;
        n_dest       = r_dest;
        n_avail      = r_avail;
        o_push       = 1'b0;
        if (accept) begin
            if (i_item.first_word) begin
                n_avail     = i_item.frame_length;
                n_version   = i_item.header_word[15:8];
                n_hdr_words = version_in_range(i_item.header_word[15:8])
                              ? {i_item.header_word[11:8], 1'b0} : DEFAULT_WORDS;
                n_sum        = i_item.header_word;
                n_total      = '0;
                n_frag       = 1'b0;
                n_proto      = '0;
                n_dest       = '0;
                n_word_index = 5'd1;
            end else if (r_word_index != 5'd0) begin
                n_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
                case (r_word_index)
                    IDX_TOTAL_LENGTH: n_total = i_item.header_word;
                    IDX_FRAGMENT:     n_frag  = (i_item.header_word[13:0] != 14'd0);
                    IDX_PROTOCOL:     n_proto = i_item.header_word[7:0];
                    IDX_DEST_HIGH:    n_dest  = {i_item.header_word, r_dest[15:0]};
                    IDX_DEST_LOW:     n_dest  = {r_dest[31:16], i_item.header_word};
                    default: ;
                endcase
                if (index_inc >= r_hdr_words) begin
                    n_word_index = 5'd0;
                    o_push       = 1'b1;
                end else begin
                    n_word_index = index_inc;
                end
            end
        end
    end

    // Job built from the updated fields so the last word counts
    always_comb begin
        o_job.destination      = n_dest;
        o_job.version_ok       = version_in_range(n_version);
        o_job.hdr_total_len    = n_total;
        o_job.available_length = n_avail;
        o_job.fragment         = n_frag;
        o_job.sum_ok           = (n_sum == 16'hffff);
        o_job.protocol         = n_proto;
        o_job.header_bytes     = {n_hdr_words, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
        end else begin
            r_word_index <= n_word_index;
        end
    end

    // Captured fields: always rewritten on a first word before use
    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_hdr_words <= n_hdr_words;
        r_version   <= n_version;
        r_total     <= n_total;
        r_frag      <= n_frag;
        r_proto     <= n_proto;
        r_dest      <= n_dest;
        r_avail     <= n_avail;
    end

endmodule

// ----- design/iprx_queue.sv -----
// iprx_queue: small FIFO of finished-header jobs between front and back.
// Depends on iprx_pkg.
`timescale 1ns / 1ps

module iprx_queue #(
    parameter int DEPTH = iprx_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iprx_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_nonempty,
    input  logic           i_pop,
    output iprx_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    iprx_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_job      = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- design/iprx_back.sv -----
// iprx_back: configuration registers, verdict decision and the result register.
// Depends on iprx_pkg.
`timescale 1ns / 1ps

module iprx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_job_valid,
    input  iprx_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output iprx_pkg::t_out_item o_item
);

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    logic [31:0]         r_host_addr;
    logic                r_filter_en;
    logic                r_valid;
    iprx_pkg::t_out_item r_item, n_item;

    assign o_pop   = i_job_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Verdict: first failing test wins
    always_comb begin
        n_item.protocol       = '0;
        n_item.payload_length = '0;
        if (r_filter_en && (i_job.destination != r_host_addr)) begin
            n_item.status = iprx_pkg::ST_WRONG_ADDR;
        end else if (!i_job.version_ok) begin
            n_item.status = iprx_pkg::ST_BAD_VERSION;
        end else if (i_job.hdr_total_len > i_job.available_length) begin
            n_item.status = iprx_pkg::ST_TOO_LONG;
        end else if (i_job.fragment) begin
            n_item.status = iprx_pkg::ST_FRAGMENT;
        end else if (!i_job.sum_ok) begin
            n_item.status = iprx_pkg::ST_BAD_SUM;
        end else begin
            if (i_job.protocol == PROTO_UDP) begin
                n_item.status = iprx_pkg::ST_UDP;
            end else if (i_job.protocol == PROTO_ICMP) begin
                n_item.status = iprx_pkg::ST_ICMP;
            end else begin
                n_item.status = iprx_pkg::ST_OTHER;
            end
            n_item.protocol       = i_job.protocol;
            n_item.payload_length = i_job.hdr_total_len - {10'd0, i_job.header_bytes};
        end
    end

    // Configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_addr <= '0;
            r_filter_en <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    iprx_pkg::CFG_HOST_ADDRESS:  r_host_addr <= i_cfg_data;
                    iprx_pkg::CFG_FILTER_ENABLE: r_filter_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- design/ipv4_receive_header_checker.sv -----
// ipv4_receive_header_checker: IPv4 header check, one 16-bit word per cycle.
// Throughput: one header word per cycle; input stalls only while the job queue
// is full. The last word's job is queued at the edge that accepts it; the back
// pops it into the result register once any held one is taken. Header length sets the
// verdict rate: one per 10 to 30 words. Reset: synchronous active low; clears header
// progress, queue and config. Depends on iprx_pkg, iprx_front, iprx_queue, iprx_back.
`timescale 1ns / 1ps

module ipv4_receive_header_checker #(
    parameter int QUEUE_DEPTH = iprx_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iprx_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iprx_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    logic           push, full, nonempty, pop;
    iprx_pkg::t_job front_job, queue_job;

    // Front: word intake and field capture
    iprx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (front_job)
    );

    // Job queue
    iprx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .o_full     (full),
        .o_nonempty (nonempty),
        .i_pop      (pop),
        .o_job      (queue_job)
    );

    // Back: verdict and result
    iprx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (nonempty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out)
    );

endmodule
